// ----- design/ssrt_pkg.sv -----
`timescale 1ns / 1ps

package ssrt_pkg;

    // operation codes on the request item
    localparam logic [2:0] OP_RESERVE_EMPTY  = 3'd0;
    localparam logic [2:0] OP_RESERVE_OLDEST = 3'd1;
    localparam logic [2:0] OP_CONFIRM_IN     = 3'd2;
    localparam logic [2:0] OP_CONFIRM_OUT    = 3'd3;
    localparam logic [2:0] OP_RELEASE        = 3'd4;
    localparam logic [2:0] OP_READ           = 3'd5;

    localparam int OP_W     = 3;
    localparam int FLOOR_W  = 3;
    localparam int SLOT_W   = 5;
    localparam int ITEM_W   = 16;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_ACCESS,
        ST_FINISH
    } state_t;

endpackage

// ----- design/ssrt_mem.sv -----
`timescale 1ns / 1ps

// Per-slot item id and arrival stamp. One write port, one registered read port.
module ssrt_mem #(
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [ssrt_pkg::ITEM_W-1:0]                witem,
    input  logic [ssrt_pkg::STAMP_W-1:0]               wstamp,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [ssrt_pkg::ITEM_W-1:0]                ritem,
    output logic [ssrt_pkg::STAMP_W-1:0]               rstamp
);

    logic [ssrt_pkg::ITEM_W-1:0]  item_mem  [DEPTH];
    logic [ssrt_pkg::STAMP_W-1:0] stamp_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            item_mem[waddr]  <= witem;
            stamp_mem[waddr] <= wstamp;
        end
    end

    always_ff @(posedge clk)
    begin
        ritem  <= item_mem[raddr];
        rstamp <= stamp_mem[raddr];
    end

endmodule

// ----- design/storage_slot_reservation_table_unit.sv -----
`timescale 1ns / 1ps
// Accept to result registered: in-range confirm/release/read pass ACCESS and FINISH;
// out-of-range addresses and unused ops only FINISH; reserve-empty scans to the first
// free slot (all N when none), reserve-oldest all N slots, then DRAIN and COMMIT, where
// N = FLOOR_COUNT * SLOTS_PER_FLOOR. The next item is taken once the result
// is registered; the scan walks one slot a cycle through the stamp/item memory.
// Reset clears all marks, the count and the stamp counter at once; memories are not cleared.
module storage_slot_reservation_table_unit #(
    parameter int FLOOR_COUNT     = 4,
    parameter int SLOTS_PER_FLOOR = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request: op[2:0], floor[5:3], slot[10:6], item_id[26:11], was_inbound[27]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ssrt_pkg::IN_DATA_W-1:0]     s_tdata,
    // result: ok[0], floor_out[3:1], slot_out[8:4], item_out[24:9],
    //         item_present[25], occupied_count[32:26], full_res[33]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ssrt_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int SLOT_TOTAL = FLOOR_COUNT * SLOTS_PER_FLOOR;
    localparam int IDX_W      = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int CNT_W      = $clog2(SLOT_TOTAL + 1);

    localparam int FW = ssrt_pkg::FLOOR_W;
    localparam int SW = ssrt_pkg::SLOT_W;
    localparam int IW = ssrt_pkg::ITEM_W;
    localparam int TW = ssrt_pkg::STAMP_W;

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    ssrt_pkg::state_t state_reg, state_next;

    logic [ssrt_pkg::OP_W-1:0] op_reg, op_next;
    logic [IW-1:0]             item_reg, item_next;
    logic                      inb_sel_reg, inb_sel_next;
    logic [IDX_W-1:0]          addr_reg, addr_next;

    // scan position
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [FW-1:0]    scan_fl_reg, scan_fl_next;
    logic [SW-1:0]    scan_sl_reg, scan_sl_next;

    // candidate waiting for its memory data
    logic             p_valid_reg, p_valid_next;
    logic [IDX_W-1:0] p_idx_reg, p_idx_next;
    logic [FW-1:0]    p_fl_reg, p_fl_next;
    logic [SW-1:0]    p_sl_reg, p_sl_next;

    // running oldest
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [FW-1:0]    best_fl_reg, best_fl_next;
    logic [SW-1:0]    best_sl_reg, best_sl_next;
    logic [TW-1:0]    best_stamp_reg, best_stamp_next;
    logic [IW-1:0]    best_item_reg, best_item_next;

    // result under construction
    logic          res_ok_reg, res_ok_next;
    logic [FW-1:0] res_fl_reg, res_fl_next;
    logic [SW-1:0] res_sl_reg, res_sl_next;
    logic [IW-1:0] res_item_reg, res_item_next;
    logic          res_present_reg, res_present_next;
    logic          res_mem_item_reg, res_mem_item_next;   // item comes from memory read

    // per-slot marks, count, stamp counter
    logic [SLOT_TOTAL-1:0] occ_reg, occ_next;
    logic [SLOT_TOTAL-1:0] inb_reg, inb_next;
    logic [SLOT_TOTAL-1:0] outb_reg, outb_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [TW-1:0]         stamp_reg, stamp_next;

    // output register
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [ssrt_pkg::OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // ---------------------------------------------------------------
    // request decode
    // ---------------------------------------------------------------
    logic                      s_accept;
    logic [ssrt_pkg::OP_W-1:0] in_op;
    logic [FW-1:0]             in_fl;
    logic [SW-1:0]             in_sl;
    logic                      in_range;
    logic [IDX_W-1:0]          in_idx;

    assign s_tready = (state_reg == ssrt_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_op    = s_tdata[2:0];
    assign in_fl    = s_tdata[5:3];
    assign in_sl    = s_tdata[10:6];

    assign in_range = (in_fl != '0) && (in_fl <= FW'(FLOOR_COUNT))
                   && (in_sl != '0) && (in_sl <= SW'(SLOTS_PER_FLOOR));
    // (floor-1)*SLOTS_PER_FLOOR + (slot-1); constant multiply on a 3-bit value
    assign in_idx   = IDX_W'(in_fl - FW'(1)) * IDX_W'(SLOTS_PER_FLOOR)
                    + IDX_W'(in_sl - SW'(1));

    // ---------------------------------------------------------------
    // memory and scan helpers
    // ---------------------------------------------------------------
    logic          mem_we;
    logic [IDX_W-1:0] mem_raddr;
    logic [IW-1:0] mem_ritem;
    logic [TW-1:0] mem_rstamp;

    assign mem_raddr = (state_reg == ssrt_pkg::ST_SCAN) ? scan_idx_reg : addr_reg;

    ssrt_mem #(
        .DEPTH (SLOT_TOTAL)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (addr_reg),
        .witem  (item_reg),
        .wstamp (stamp_reg),
        .raddr  (mem_raddr),
        .ritem  (mem_ritem),
        .rstamp (mem_rstamp)
    );

    logic scan_free;
    logic scan_qual;
    logic scan_last;
    logic older;
    logic out_free;

    assign scan_free = !occ_reg[scan_idx_reg] && !inb_reg[scan_idx_reg]
                    && !outb_reg[scan_idx_reg];
    assign scan_qual = occ_reg[scan_idx_reg] && !outb_reg[scan_idx_reg];
    assign scan_last = (scan_idx_reg == IDX_W'(SLOT_TOTAL - 1));
    // the oldest-search compare: strict less keeps the lowest index on a tie
    assign older     = !found_reg || (mem_rstamp < best_stamp_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssrt_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_op)
                        ssrt_pkg::OP_RESERVE_EMPTY,
                        ssrt_pkg::OP_RESERVE_OLDEST:
                            state_next = ssrt_pkg::ST_SCAN;
                        ssrt_pkg::OP_CONFIRM_IN,
                        ssrt_pkg::OP_CONFIRM_OUT,
                        ssrt_pkg::OP_RELEASE,
                        ssrt_pkg::OP_READ:
                            state_next = in_range ? ssrt_pkg::ST_ACCESS
                                                  : ssrt_pkg::ST_FINISH;
                        default:
                            state_next = ssrt_pkg::ST_FINISH;
                    endcase
                end
            end
            ssrt_pkg::ST_SCAN:
            begin
                if (op_reg == ssrt_pkg::OP_RESERVE_EMPTY)
                begin
                    if (scan_free || scan_last)
                        state_next = ssrt_pkg::ST_FINISH;
                end
                else if (scan_last)
                begin
                    state_next = ssrt_pkg::ST_DRAIN;
                end
            end
            ssrt_pkg::ST_DRAIN:  state_next = ssrt_pkg::ST_COMMIT;
            ssrt_pkg::ST_COMMIT: state_next = ssrt_pkg::ST_FINISH;
            ssrt_pkg::ST_ACCESS: state_next = ssrt_pkg::ST_FINISH;
            ssrt_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = ssrt_pkg::ST_IDLE;
            end
            default: state_next = ssrt_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    logic [IW-1:0] fin_item;

    always_comb
    begin
        op_next          = op_reg;
        item_next        = item_reg;
        inb_sel_next     = inb_sel_reg;
        addr_next        = addr_reg;
        scan_idx_next    = scan_idx_reg;
        scan_fl_next     = scan_fl_reg;
        scan_sl_next     = scan_sl_reg;
        p_valid_next     = p_valid_reg;
        p_idx_next       = p_idx_reg;
        p_fl_next        = p_fl_reg;
        p_sl_next        = p_sl_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_fl_next     = best_fl_reg;
        best_sl_next     = best_sl_reg;
        best_stamp_next  = best_stamp_reg;
        best_item_next   = best_item_reg;
        res_ok_next      = res_ok_reg;
        res_fl_next      = res_fl_reg;
        res_sl_next      = res_sl_reg;
        res_item_next    = res_item_reg;
        res_present_next = res_present_reg;
        res_mem_item_next = res_mem_item_reg;
        occ_next         = occ_reg;
        inb_next         = inb_reg;
        outb_next        = outb_reg;
        total_next       = total_reg;
        stamp_next       = stamp_reg;
        mem_we           = 1'b0;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        fin_item = res_mem_item_reg ? (res_present_reg ? mem_ritem : '0) : res_item_reg;

        // compare stage of the oldest search
        if ((state_reg == ssrt_pkg::ST_SCAN || state_reg == ssrt_pkg::ST_DRAIN)
            && p_valid_reg && older)
        begin
            found_next      = 1'b1;
            best_idx_next   = p_idx_reg;
            best_fl_next    = p_fl_reg;
            best_sl_next    = p_sl_reg;
            best_stamp_next = mem_rstamp;
            best_item_next  = mem_ritem;
        end

        unique case (state_reg)
            ssrt_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next           = in_op;
                    item_next         = s_tdata[26:11];
                    inb_sel_next      = s_tdata[27];
                    addr_next         = in_idx;
                    scan_idx_next     = '0;
                    scan_fl_next      = FW'(1);
                    scan_sl_next      = SW'(1);
                    p_valid_next      = 1'b0;
                    found_next        = 1'b0;
                    res_ok_next       = 1'b0;
                    res_fl_next       = '0;
                    res_sl_next       = '0;
                    res_item_next     = '0;
                    res_present_next  = 1'b0;
                    res_mem_item_next = 1'b0;
                end
            end
            ssrt_pkg::ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_sl_reg == SW'(SLOTS_PER_FLOOR))
                begin
                    scan_sl_next = SW'(1);
                    scan_fl_next = scan_fl_reg + FW'(1);
                end
                else
                begin
                    scan_sl_next = scan_sl_reg + SW'(1);
                end
                p_valid_next = (op_reg == ssrt_pkg::OP_RESERVE_OLDEST) && scan_qual;
                p_idx_next   = scan_idx_reg;
                p_fl_next    = scan_fl_reg;
                p_sl_next    = scan_sl_reg;
                if (op_reg == ssrt_pkg::OP_RESERVE_EMPTY && scan_free)
                begin
                    inb_next[scan_idx_reg] = 1'b1;
                    res_ok_next = 1'b1;
                    res_fl_next = scan_fl_reg;
                    res_sl_next = scan_sl_reg;
                end
            end
            ssrt_pkg::ST_DRAIN:
            begin
                p_valid_next = 1'b0;
            end
            ssrt_pkg::ST_COMMIT:
            begin
                if (found_reg)
                begin
                    outb_next[best_idx_reg] = 1'b1;
                    res_ok_next      = 1'b1;
                    res_fl_next      = best_fl_reg;
                    res_sl_next      = best_sl_reg;
                    res_item_next    = best_item_reg;
                    res_present_next = 1'b1;
                end
            end
            ssrt_pkg::ST_ACCESS:
            begin
                res_ok_next = 1'b1;
                unique case (op_reg)
                    ssrt_pkg::OP_CONFIRM_IN:
                    begin
                        if (!occ_reg[addr_reg])
                            total_next = total_reg + CNT_W'(1);
                        occ_next[addr_reg] = 1'b1;
                        inb_next[addr_reg] = 1'b0;
                        mem_we = 1'b1;
                        if (stamp_reg != ssrt_pkg::STAMP_MAX)
                            stamp_next = stamp_reg + TW'(1);
                    end
                    ssrt_pkg::OP_CONFIRM_OUT:
                    begin
                        if (occ_reg[addr_reg] && total_reg != '0)
                            total_next = total_reg - CNT_W'(1);
                        occ_next[addr_reg]  = 1'b0;
                        outb_next[addr_reg] = 1'b0;
                    end
                    ssrt_pkg::OP_RELEASE:
                    begin
                        if (inb_sel_reg)
                            inb_next[addr_reg] = 1'b0;
                        else
                            outb_next[addr_reg] = 1'b0;
                    end
                    ssrt_pkg::OP_READ:
                    begin
                        res_present_next  = occ_reg[addr_reg];
                        res_mem_item_next = 1'b1;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end
            ssrt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0,
                                     (total_reg >= CNT_W'(SLOT_TOTAL)),
                                     ssrt_pkg::COUNT_W'(total_reg),
                                     res_present_reg,
                                     fin_item,
                                     res_sl_reg,
                                     res_fl_reg,
                                     res_ok_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssrt_pkg::ST_IDLE;
            occ_reg      <= '0;
            inb_reg      <= '0;
            outb_reg     <= '0;
            total_reg    <= '0;
            stamp_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            inb_reg      <= inb_next;
            outb_reg     <= outb_next;
            total_reg    <= total_next;
            stamp_reg    <= stamp_next;
            m_tvalid_reg <= m_tvalid_next;
            p_valid_reg  <= p_valid_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        item_reg         <= item_next;
        inb_sel_reg      <= inb_sel_next;
        addr_reg         <= addr_next;
        scan_idx_reg     <= scan_idx_next;
        scan_fl_reg      <= scan_fl_next;
        scan_sl_reg      <= scan_sl_next;
        p_idx_reg        <= p_idx_next;
        p_fl_reg         <= p_fl_next;
        p_sl_reg         <= p_sl_next;
        best_idx_reg     <= best_idx_next;
        best_fl_reg      <= best_fl_next;
        best_sl_reg      <= best_sl_next;
        best_stamp_reg   <= best_stamp_next;
        best_item_reg    <= best_item_next;
        res_ok_reg       <= res_ok_next;
        res_fl_reg       <= res_fl_next;
        res_sl_reg       <= res_sl_next;
        res_item_reg     <= res_item_next;
        res_present_reg  <= res_present_next;
        res_mem_item_reg <= res_mem_item_next;
        m_tdata_reg      <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // count tracks the occupied marks exactly
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) == int'(total_reg))
        else $error("occupied count out of step with marks");

    // only one item in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("second item accepted while busy");

    // a scan only runs for the two reserve operations
    a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssrt_pkg::ST_SCAN) |->
        (op_reg == ssrt_pkg::OP_RESERVE_EMPTY || op_reg == ssrt_pkg::OP_RESERVE_OLDEST))
        else $error("scan entered for a non-reserve op");

    // stamp counter never goes backward while the block is busy
    a_stamp_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ssrt_pkg::ST_IDLE) |=> stamp_reg >= $past(stamp_reg))
        else $error("stamp counter decreased");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int FLOORS = 4;
    localparam int SLOTS  = 16;
    localparam int TOTAL  = FLOORS * SLOTS;
    localparam int HOLD_LEN = 400;

    // op codes with no meaning; the block must leave the table alone
    localparam logic [ssrt_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [ssrt_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;

    // last field in the lowest bits
    typedef struct packed {
        logic                         was_inbound;
        logic [ssrt_pkg::ITEM_W-1:0]  item_id;
        logic [ssrt_pkg::SLOT_W-1:0]  slot;
        logic [ssrt_pkg::FLOOR_W-1:0] floor;
        logic [ssrt_pkg::OP_W-1:0]    op;
    } slot_request_t;

    typedef struct packed {
        logic                         full_res;
        logic [ssrt_pkg::COUNT_W-1:0] occupied_count;
        logic                         item_present;
        logic [ssrt_pkg::ITEM_W-1:0]  item_out;
        logic [ssrt_pkg::SLOT_W-1:0]  slot_out;
        logic [ssrt_pkg::FLOOR_W-1:0] floor_out;
        logic                         ok;
    } slot_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ssrt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ssrt_pkg::OUT_DATA_W-1:0] m_tdata;

    // table model
    bit                           occ_mark [TOTAL];
    bit                           in_hold  [TOTAL];
    bit                           out_hold [TOTAL];
    logic [ssrt_pkg::ITEM_W-1:0]  item_store [TOTAL];
    logic [ssrt_pkg::STAMP_W-1:0] arrival [TOTAL];
    logic [ssrt_pkg::STAMP_W-1:0] next_arrival;
    int                           occ_total;

    slot_result_t pending_results[$];
    slot_result_t last_result;
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_start = 1'b0;
    int           hold_cycles = 0;

    storage_slot_reservation_table_unit #(
        .FLOOR_COUNT    (FLOORS),
        .SLOTS_PER_FLOOR(SLOTS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_table_model();
        for (int i = 0; i < TOTAL; i++)
        begin
            occ_mark[i] = 0;
            in_hold[i] = 0;
            out_hold[i] = 0;
            item_store[i] = '0;
            arrival[i] = '0;
        end
        next_arrival = '0;
        occ_total = 0;
    endfunction

    // Applies one request to the table model and returns the result the
    // block must give for it.
    function automatic slot_result_t predict_slot_table(slot_request_t r);
        slot_result_t res;
        bit           found;
        bit           in_range;
        int           best;
        int           idx;
        int           fo;
        int           so;
        res = '0;
        found = 0;
        best = 0;
        in_range = r.floor >= 1 && r.floor <= FLOORS && r.slot >= 1 && r.slot <= SLOTS;
        idx = (int'(r.floor) - 1) * SLOTS + int'(r.slot) - 1;
        case (r.op)
            ssrt_pkg::OP_RESERVE_EMPTY:
            begin
                for (int i = 0; i < TOTAL; i++)
                    if (!found && !occ_mark[i] && !in_hold[i] && !out_hold[i])
                    begin
                        found = 1;
                        best = i;
                    end
                if (found)
                begin
                    in_hold[best] = 1;
                    fo = best / SLOTS + 1;
                    so = best % SLOTS + 1;
                    res.ok = 1'b1;
                    res.floor_out = fo[ssrt_pkg::FLOOR_W-1:0];
                    res.slot_out = so[ssrt_pkg::SLOT_W-1:0];
                end
            end
            ssrt_pkg::OP_RESERVE_OLDEST:
            begin
                // strict compare keeps the lowest index on equal stamps
                for (int i = 0; i < TOTAL; i++)
                    if (occ_mark[i] && !out_hold[i] && (!found || arrival[i] < arrival[best]))
                    begin
                        found = 1;
                        best = i;
                    end
                if (found)
                begin
                    out_hold[best] = 1;
                    fo = best / SLOTS + 1;
                    so = best % SLOTS + 1;
                    res.ok = 1'b1;
                    res.floor_out = fo[ssrt_pkg::FLOOR_W-1:0];
                    res.slot_out = so[ssrt_pkg::SLOT_W-1:0];
                    res.item_out = item_store[best];
                    res.item_present = 1'b1;
                end
            end
            ssrt_pkg::OP_CONFIRM_IN, ssrt_pkg::OP_CONFIRM_OUT, ssrt_pkg::OP_RELEASE,
            ssrt_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    res.ok = 1'b1;
                    case (r.op)
                        ssrt_pkg::OP_CONFIRM_IN:
                        begin
                            if (!occ_mark[idx])
                                occ_total++;
                            occ_mark[idx] = 1;
                            item_store[idx] = r.item_id;
                            arrival[idx] = next_arrival;
                            if (next_arrival != ssrt_pkg::STAMP_MAX)
                                next_arrival++;
                            in_hold[idx] = 0;
                        end
                        ssrt_pkg::OP_CONFIRM_OUT:
                        begin
                            if (occ_mark[idx] && occ_total > 0)
                                occ_total--;
                            occ_mark[idx] = 0;
                            out_hold[idx] = 0;
                        end
                        ssrt_pkg::OP_RELEASE:
                        begin
                            if (r.was_inbound)
                                in_hold[idx] = 0;
                            else
                                out_hold[idx] = 0;
                        end
                        default:
                        begin
                            if (occ_mark[idx])
                            begin
                                res.item_out = item_store[idx];
                                res.item_present = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        res.occupied_count = occ_total[ssrt_pkg::COUNT_W-1:0];
        res.full_res = occ_total >= TOTAL;
        return res;
    endfunction

    function automatic slot_request_t make_request(logic [ssrt_pkg::OP_W-1:0] op, int fl,
                                                   int sl, int id, bit wi);
        slot_request_t r;
        r.op = op;
        r.floor = fl[ssrt_pkg::FLOOR_W-1:0];
        r.slot = sl[ssrt_pkg::SLOT_W-1:0];
        r.item_id = id[ssrt_pkg::ITEM_W-1:0];
        r.was_inbound = wi;
        return r;
    endfunction

    // Offers one item, waits for the handshake and queues its expected result.
    task automatic send_request(input slot_request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(ssrt_pkg::IN_DATA_W - $bits(slot_request_t)){1'b0}}, r};
        do
            @(posedge clk);
        while (!s_tready);
        last_result = predict_slot_table(r);
        pending_results.push_back(last_result);
    endtask

    task automatic send_op(logic [ssrt_pkg::OP_W-1:0] op, int fl, int sl, int id, bit wi);
        send_request(make_request(op, fl, sl, id, wi));
    endtask

    // Receiver: random stalls, plus one counted hold-off once it is started.
    always @(posedge clk)
    begin
        if (hold_start && hold_cycles < HOLD_LEN)
        begin
            hold_cycles = hold_cycles + 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        slot_result_t want;
        slot_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(slot_result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("ok", 32'(want.ok), 32'(got.ok));
                check_field("floor_out", 32'(want.floor_out), 32'(got.floor_out));
                check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
                check_field("item_out", 32'(want.item_out), 32'(got.item_out));
                check_field("item_present", 32'(want.item_present), 32'(got.item_present));
                check_field("occupied_count", 32'(want.occupied_count),
                            32'(got.occupied_count));
                check_field("full_res", 32'(want.full_res), 32'(got.full_res));
            end
        end
    end

    // Empty-table reads, first reservation, inbound onto an occupied slot.
    task automatic test_empty_table();
        send_op(ssrt_pkg::OP_READ, 1, 1, 0, 0);
        send_op(ssrt_pkg::OP_RESERVE_OLDEST, 0, 0, 0, 0);
        send_op(ssrt_pkg::OP_RESERVE_EMPTY, 0, 0, 0, 0);
        send_op(ssrt_pkg::OP_CONFIRM_IN, 1, 1, 16'hFFFF, 1);
        send_op(ssrt_pkg::OP_CONFIRM_IN, FLOORS, SLOTS, 16'h0000, 0);
        // restamps 1.1, so the far corner becomes the oldest
        send_op(ssrt_pkg::OP_CONFIRM_IN, 1, 1, 16'h1234, 0);
    endtask

    task automatic test_oldest_order();
        send_op(ssrt_pkg::OP_RESERVE_OLDEST, 0, 0, 0, 0);
        send_op(ssrt_pkg::OP_RESERVE_OLDEST, 7, 31, 16'hFFFF, 1);
        send_op(ssrt_pkg::OP_RESERVE_OLDEST, 0, 0, 0, 0);
        send_op(ssrt_pkg::OP_RELEASE, 1, 1, 0, 0);
        send_op(ssrt_pkg::OP_RELEASE, 1, 1, 0, 1);
        send_op(ssrt_pkg::OP_READ, 1, 1, 0, 0);
    endtask

    task automatic test_removal();
        send_op(ssrt_pkg::OP_CONFIRM_OUT, FLOORS, SLOTS, 0, 0);
        send_op(ssrt_pkg::OP_CONFIRM_OUT, FLOORS, SLOTS, 0, 0);
        send_op(ssrt_pkg::OP_READ, FLOORS, SLOTS, 0, 0);
    endtask

    task automatic test_bad_addresses();
        send_op(ssrt_pkg::OP_READ, 0, 1, 0, 0);
        send_op(ssrt_pkg::OP_CONFIRM_IN, FLOORS + 1, 1, 16'hAAAA, 0);
        send_op(ssrt_pkg::OP_RELEASE, 7, 31, 0, 1);
        send_op(ssrt_pkg::OP_CONFIRM_OUT, 1, 0, 0, 0);
        send_op(ssrt_pkg::OP_READ, 1, SLOTS + 1, 0, 0);
        send_op(OP_UNUSED_A, 1, 1, 16'h5555, 1);
        send_op(OP_UNUSED_B, 7, 31, 16'hFFFF, 1);
    endtask

    // Put an inbound hold on every free slot until none is left, then drop them.
    task automatic test_hold_exhaustion();
        for (int i = 0; i <= TOTAL; i++)
            send_op(ssrt_pkg::OP_RESERVE_EMPTY, 0, 0, 0, 0);
        for (int i = 0; i < TOTAL; i++)
            send_op(ssrt_pkg::OP_RELEASE, i / SLOTS + 1, i % SLOTS + 1, 0, 1);
    endtask

    task automatic test_fill_and_drain();
        for (int i = 0; i < TOTAL; i++)
            send_op(ssrt_pkg::OP_CONFIRM_IN, i / SLOTS + 1, i % SLOTS + 1,
                    int'($urandom_range(16'hFFFF)), 0);
        send_op(ssrt_pkg::OP_RESERVE_EMPTY, 0, 0, 0, 0);
        for (int i = 0; i <= TOTAL; i++)
            send_op(ssrt_pkg::OP_RESERVE_OLDEST, 0, 0, 0, 0);
        for (int i = TOTAL - 1; i >= 0; i--)
            send_op(ssrt_pkg::OP_CONFIRM_OUT, i / SLOTS + 1, i % SLOTS + 1, 0, 0);
    endtask

    // One mixed step: mostly reserve-then-confirm pairs, some reads, some noise.
    task automatic send_traffic_step();
        int                        pick;
        int unsigned               op_draw;
        logic [ssrt_pkg::OP_W-1:0] op;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            send_op(ssrt_pkg::OP_RESERVE_EMPTY, int'($urandom_range(7)),
                    int'($urandom_range(31)), 0, 0);
            if (last_result.ok)
            begin
                if ($urandom_range(99) < 85)
                    send_op(ssrt_pkg::OP_CONFIRM_IN, int'(last_result.floor_out),
                            int'(last_result.slot_out), int'($urandom_range(16'hFFFF)),
                            $urandom_range(1) != 0);
                else
                    send_op(ssrt_pkg::OP_RELEASE, int'(last_result.floor_out),
                            int'(last_result.slot_out), 0, 1);
            end
        end
        else if (pick < 58)
        begin
            send_op(ssrt_pkg::OP_RESERVE_OLDEST, int'($urandom_range(7)),
                    int'($urandom_range(31)), 0, 0);
            if (last_result.ok)
            begin
                if ($urandom_range(99) < 80)
                    send_op(ssrt_pkg::OP_CONFIRM_OUT, int'(last_result.floor_out),
                            int'(last_result.slot_out), 0, 0);
                else
                    send_op(ssrt_pkg::OP_RELEASE, int'(last_result.floor_out),
                            int'(last_result.slot_out), 0, 0);
            end
        end
        else if (pick < 75)
        begin
            op_draw = $urandom_range(ssrt_pkg::OP_CONFIRM_IN, ssrt_pkg::OP_READ);
            op = op_draw[ssrt_pkg::OP_W-1:0];
            send_op(op, int'($urandom_range(1, FLOORS)), int'($urandom_range(1, SLOTS)),
                    int'($urandom_range(16'hFFFF)), $urandom_range(1) != 0);
        end
        else
        begin
            op_draw = $urandom_range(7);
            op = op_draw[ssrt_pkg::OP_W-1:0];
            send_op(op, int'($urandom_range(7)), int'($urandom_range(31)),
                    int'($urandom_range(16'hFFFF)), $urandom_range(1) != 0);
        end
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
            send_traffic_step();
    endtask

    // Receiver stops for a long stretch while items keep coming.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start = 1'b1;
        for (int n = 0; n < 20; n++)
            send_traffic_step();
    endtask

    initial
    begin
        clear_table_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 70;
        test_empty_table();
        test_oldest_order();
        test_removal();
        test_bad_addresses();
        test_hold_exhaustion();
        test_fill_and_drain();
        test_random_traffic(16, 70, 200);
        test_backpressure();
        test_random_traffic(70, 16, 200);
        test_random_traffic(0, 0, 200);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ssrt_pkg.sv
design/ssrt_mem.sv
design/storage_slot_reservation_table_unit.sv
tb/testbench.sv
